// File: design/dsq_pkg.sv
// ============================================================================
// dsq_pkg
// Shared constants, step table and pipeline word types of the deadzone
// spectral quantizer.
// ============================================================================
package dsq_pkg;

   // Field widths
   localparam int unsigned SAMPLE_W   = 32;
   localparam int unsigned BEXP_W     = 8;
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned GAIN_W     = 8;
   localparam int unsigned SEXP_W     = 7;
   localparam int unsigned BIAS_W     = 8;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned CSR_IDX_W  = 2;

   // Datapath widths
   localparam int unsigned MAG_W    = 31;  // magnitude, saturated to 2^31-1
   localparam int unsigned MANT_W   = 29;  // Q28 mantissa of the inverse step
   localparam int unsigned PROD_W   = MAG_W + MANT_W;
   localparam int unsigned RSHIFT_W = 9;   // signed, spans -83..140
   localparam int unsigned EXP_W    = 11;  // signed step exponent work width
   localparam int unsigned SCALED_W = 31;  // Q8 value, saturated to 2^31-1

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_GAIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_EXPONENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_BIAS     = 2'd2;

   // Reset values
   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd0;
   localparam logic [SEXP_W-1:0] SEXP_RESET = 7'd0;
   localparam logic [BIAS_W-1:0] BIAS_RESET = 8'd128;

   // Quantizer constants
   localparam logic signed [EXP_W-1:0] STEP_EXP_OFFSET = 11'sd59;
   localparam logic signed [EXP_W-1:0] TOTAL_Q         = 11'sd51;
   localparam logic [SCALED_W-1:0]     DZ_THRESH_Q8    = 31'd167;
   localparam logic [SCALED_W-1:0]     Q8_MAX          = {SCALED_W{1'b1}};
   localparam logic [LEVEL_W-2:0]      LEVEL_MAX       = {(LEVEL_W-1){1'b1}};

   // 2^(f/8) in Q30, returned as a Q28 mantissa
   function automatic logic [MANT_W-1:0] step_mantissa(input logic [2:0] frac);
      logic [31:0] q30;
      begin
         unique case (frac)
            3'd0: q30 = 32'd1073741824;
            3'd1: q30 = 32'd1170923762;
            3'd2: q30 = 32'd1276901417;
            3'd3: q30 = 32'd1392470869;
            3'd4: q30 = 32'd1518500250;
            3'd5: q30 = 32'd1655936265;
            3'd6: q30 = 32'd1805811301;
            default: q30 = 32'd1969251188;
         endcase
         step_mantissa = q30[MANT_W+1:2];
      end
   endfunction

   // Word entering the pipe
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [BEXP_W-1:0]   bexp;
   } in_type;

   // After sign split and step formation
   typedef struct packed {
      logic                       valid;
      logic                       neg;
      logic [MAG_W-1:0]           mag;
      logic [MANT_W-1:0]          mant;
      logic signed [RSHIFT_W-1:0] rshift;
   } prep_type;

   // After the multiply
   typedef struct packed {
      logic                       valid;
      logic                       neg;
      logic [PROD_W-1:0]          prod;
      logic signed [RSHIFT_W-1:0] rshift;
   } prod_type;

   // After the binary shift
   typedef struct packed {
      logic                valid;
      logic                neg;
      logic [SCALED_W-1:0] scaled;
   } scaled_type;

endpackage

// File: design/dsq_skid.sv
// ============================================================================
// dsq_skid
// Input skid stage: parks one word while the pipe holds, so that req_stall
// comes straight from a register.
// ============================================================================
module dsq_skid
   import dsq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic signed [SAMPLE_W-1:0] req_spectrum_sample,
   input  logic signed [BEXP_W-1:0]   req_bin_exponent,
   output logic                       req_stall,
   input  logic                       advance,
   output in_type                     src
);

   logic                       skid_valid_ff, skid_valid_in;
   logic signed [SAMPLE_W-1:0] skid_sample_ff;
   logic signed [BEXP_W-1:0]   skid_bexp_ff;
   logic                       accept;

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Parked word has priority over the port
   always_comb begin
      src.valid  = skid_valid_ff || accept;
      src.sample = skid_valid_ff ? skid_sample_ff : req_spectrum_sample;
      src.bexp   = skid_valid_ff ? skid_bexp_ff : req_bin_exponent;
   end

   assign skid_valid_in = advance ? 1'b0 : (skid_valid_ff || accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Park an accepted word while the pipe holds
   always_ff @(posedge clock) begin
      if (accept && !advance) begin
         skid_sample_ff <= req_spectrum_sample;
         skid_bexp_ff   <= req_bin_exponent;
      end
   end

endmodule

// File: design/dsq_prep.sv
// ============================================================================
// dsq_prep
// Stage 1: sample magnitude and sign, step exponent, table mantissa and
// the net binary shift.
// ============================================================================
module dsq_prep
   import dsq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  in_type                   src,
   input  logic [GAIN_W-1:0]        step_gain,
   input  logic signed [SEXP_W-1:0] block_exponent,
   output prep_type                 s1
);

   prep_type                 s1_ff, s1_in;
   logic signed [SAMPLE_W-1:0] neg_sample;
   logic signed [EXP_W-1:0]  e_val;
   logic signed [EXP_W-1:0]  oct;
   logic signed [EXP_W-1:0]  rs_full;

   always_comb begin
      // Magnitude; the most negative sample saturates
      neg_sample = -src.sample;
      s1_in.valid = src.valid;
      s1_in.neg   = src.sample[SAMPLE_W-1];
      if (src.sample == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
         s1_in.mag = {MAG_W{1'b1}};
      end else if (src.sample[SAMPLE_W-1]) begin
         s1_in.mag = neg_sample[MAG_W-1:0];
      end else begin
         s1_in.mag = src.sample[MAG_W-1:0];
      end

      // Step exponent E = gain + 59 - 2*bexp, split in octave and eighth
      e_val = $signed({{(EXP_W-GAIN_W){1'b0}}, step_gain}) + STEP_EXP_OFFSET
            - ($signed({{(EXP_W-BEXP_W){src.bexp[BEXP_W-1]}}, src.bexp}) <<< 1);
      oct   = e_val >>> 3;
      s1_in.mant = step_mantissa(e_val[2:0]);

      rs_full = TOTAL_Q
              - $signed({{(EXP_W-SEXP_W){block_exponent[SEXP_W-1]}}, block_exponent})
              - oct;
      s1_in.rshift = rs_full[RSHIFT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff.valid <= s1_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff.neg    <= s1_in.neg;
         s1_ff.mag    <= s1_in.mag;
         s1_ff.mant   <= s1_in.mant;
         s1_ff.rshift <= s1_in.rshift;
      end
   end

   assign s1 = s1_ff;

endmodule

// File: design/dsq_scale.sv
// ============================================================================
// dsq_scale
// Stages 2 and 3: magnitude times mantissa, then the binary shift to Q8
// with saturation on overflow and zero for very coarse steps.
// ============================================================================
module dsq_scale
   import dsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  prep_type   s1,
   output scaled_type s3
);

   localparam int unsigned LSH_W = PROD_W + 32;

   prod_type             s2_ff;
   scaled_type           s3_ff, s3_in;
   logic [PROD_W-1:0]    rsh;
   logic [LSH_W-1:0]     lsh;
   logic signed [RSHIFT_W:0] ls;

   // Stage 2: multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_ff.valid <= s1.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff.neg    <= s1.neg;
         s2_ff.prod   <= PROD_W'(s1.mag) * PROD_W'(s1.mant);
         s2_ff.rshift <= s1.rshift;
      end
   end

   // Stage 3: shift into Q8
   always_comb begin
      ls  = -$signed({s2_ff.rshift[RSHIFT_W-1], s2_ff.rshift});
      rsh = s2_ff.prod >> s2_ff.rshift[5:0];
      lsh = {32'd0, s2_ff.prod} << ls[4:0];
      s3_in.valid = s2_ff.valid;
      s3_in.neg   = s2_ff.neg;
      if (s2_ff.rshift >= $signed(RSHIFT_W'(64))) begin
         s3_in.scaled = '0;
      end else if (s2_ff.rshift > $signed(RSHIFT_W'(0))) begin
         s3_in.scaled = (|rsh[PROD_W-1:SCALED_W]) ? Q8_MAX : rsh[SCALED_W-1:0];
      end else if (s2_ff.prod == '0) begin
         s3_in.scaled = '0;
      end else if (ls >= $signed((RSHIFT_W+1)'(32))) begin
         s3_in.scaled = Q8_MAX;
      end else begin
         s3_in.scaled = (|lsh[LSH_W-1:SCALED_W]) ? Q8_MAX : lsh[SCALED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_ff.valid <= s3_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff.neg    <= s3_in.neg;
         s3_ff.scaled <= s3_in.scaled;
      end
   end

   assign s3 = s3_ff;

endmodule

// File: design/dsq_level.sv
// ============================================================================
// dsq_level
// Stage 4: deadzone, rounding bias, level saturation and sign, into the
// output register.
// ============================================================================
module dsq_level
   import dsq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  scaled_type                 s3,
   input  logic [BIAS_W-1:0]          round_bias,
   output logic                       rsp_valid,
   output logic signed [LEVEL_W-1:0]  rsp_quant_level
);

   logic                      rsp_valid_ff;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic [SCALED_W:0]         biased;
   logic [SCALED_W-8:0]       q_wide;
   logic [LEVEL_W-2:0]        q_sat;
   logic [LEVEL_W-1:0]        q_ext;

   always_comb begin
      biased = {1'b0, s3.scaled} + (SCALED_W+1)'(round_bias);
      q_wide = biased[SCALED_W:8];
      q_sat  = (q_wide > (SCALED_W-7)'(LEVEL_MAX)) ? LEVEL_MAX : q_wide[LEVEL_W-2:0];
      q_ext  = (s3.scaled < DZ_THRESH_Q8) ? '0 : {1'b0, q_sat};
      level_in = s3.neg ? $signed(-q_ext) : $signed(q_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quant_level = level_ff;

endmodule

// File: design/deadzone_spectral_quantizer.sv
// ============================================================================
// deadzone_spectral_quantizer
// Deadzone uniform quantizer for Q31 spectral bins with an eighth-octave
// power-of-two step.
// ============================================================================
// Usage:
//   req_ channel: one word per bin, spectrum_sample (Q31) and bin_exponent.
//   rsp_ channel: one quant_level per accepted word, in arrival order.
//   Both channels use valid/stall; a word moves when valid is high and
//   stall is low.
//   csr_ port: write step_gain (0), block_exponent (1), round_bias (2) while
//   the block is idle; index 3 is ignored.
//   Path: an accepted word passes the stage 1, 2 and 3 registers and
//   the output register. Throughput: one word per cycle while rsp_ is not
//   stalled. Four stages: step formation, multiply, shift, deadzone/round.
//   Stall: a stalled rsp_ word holds; the whole pipe freezes and one more
//   req_ word is parked in the input skid register, after which req_stall
//   rises. req_stall is a register output.
//   Reset: clears all valid bits and sets the registers to step_gain 0,
//   block_exponent 0, round_bias 128.
// ============================================================================
module deadzone_spectral_quantizer
   import dsq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_spectrum_sample,
   input  logic signed [BEXP_W-1:0]   req_bin_exponent,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [LEVEL_W-1:0]  rsp_quant_level,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   logic [GAIN_W-1:0]        step_gain_ff;
   logic signed [SEXP_W-1:0] block_exponent_ff;
   logic [BIAS_W-1:0]        round_bias_ff;
   logic                     advance;
   in_type                   src;
   prep_type                 s1;
   scaled_type               s3;

   // Pipe moves unless the output word is held
   assign advance = !rsp_valid || !rsp_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_gain_ff      <= GAIN_RESET;
         block_exponent_ff <= SEXP_RESET;
         round_bias_ff     <= BIAS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STEP_GAIN:      step_gain_ff      <= csr_write_data[GAIN_W-1:0];
            CSR_BLOCK_EXPONENT: block_exponent_ff <= csr_write_data[SEXP_W-1:0];
            CSR_ROUND_BIAS:     round_bias_ff     <= csr_write_data[BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   dsq_skid u_skid (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_spectrum_sample (req_spectrum_sample),
      .req_bin_exponent    (req_bin_exponent),
      .req_stall           (req_stall),
      .advance             (advance),
      .src                 (src)
   );

   dsq_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .src            (src),
      .step_gain      (step_gain_ff),
      .block_exponent (block_exponent_ff),
      .s1             (s1)
   );

   dsq_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .s1      (s1),
      .s3      (s3)
   );

   dsq_level u_level (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .s3              (s3),
      .round_bias      (round_bias_ff),
      .rsp_valid       (rsp_valid),
      .rsp_quant_level (rsp_quant_level)
   );

endmodule

// File: design/dsq_checker.sv
// ============================================================================
// dsq_checker
// Port-level checks of the deadzone spectral quantizer, bound to the top.
// ============================================================================
module dsq_checker
   import dsq_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [LEVEL_W-1:0]  rsp_quant_level
);

   // No word comes out of a freshly reset pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // A held output word keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quant_level))
      else $error("held rsp word changed");

   // Levels stay symmetric: the most negative code never appears
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quant_level != {1'b1, {(LEVEL_W-1){1'b0}}})
      else $error("quant_level out of range");

   // The input only stalls after the output was held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall && req_valid))
      else $error("req_stall rose without an output hold");

endmodule

bind deadzone_spectral_quantizer dsq_checker u_dsq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_quant_level (rsp_quant_level)
);

// File: bench/quant_level_monitor.sv
// ============================================================================
// quant_level_monitor
// Watches the req_, rsp_ and csr_ ports of the deadzone spectral quantizer.
// It predicts the level of every accepted word from its own register copy
// and compares each delivered level with the oldest prediction, in order.
// ============================================================================
`timescale 1ns / 1ps
module quant_level_monitor
   import dsq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_spectrum_sample,
   input  logic signed [BEXP_W-1:0]   req_bin_exponent,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [LEVEL_W-1:0]  rsp_quant_level,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data,
   output int                         fail_count,
   output int                         outstanding,
   output int                         checked
);

   localparam int          STEP_OFFSET   = 59;
   localparam int          TOTAL_FRAC    = 51;
   localparam logic [63:0] DEADZONE_Q8   = 64'd167;
   localparam logic [63:0] Q8_LIMIT      = 64'd2147483647;
   localparam logic [63:0] LEVEL_LIMIT   = 64'd32767;
   localparam logic [63:0] MAG_LIMIT     = 64'd2147483647;

   typedef struct {
      logic signed [SAMPLE_W-1:0] coef;
      logic signed [BEXP_W-1:0]   bexp;
      logic signed [LEVEL_W-1:0]  level;
   } level_entry_type;

   level_entry_type pending_levels[$];

   // register copy
   logic [GAIN_W-1:0]        step_gain;
   logic signed [SEXP_W-1:0] block_exp;
   logic [BIAS_W-1:0]        round_bias;

   // 2^(f/8) in Q30
   function automatic logic [63:0] eighth_octave_q30(input logic [2:0] f);
      case (f)
         3'd0: return 64'd1073741824;
         3'd1: return 64'd1170923762;
         3'd2: return 64'd1276901417;
         3'd3: return 64'd1392470869;
         3'd4: return 64'd1518500250;
         3'd5: return 64'd1655936265;
         3'd6: return 64'd1805811301;
         default: return 64'd1969251188;
      endcase
   endfunction

   // level of one bin under the current register copy
   function automatic logic signed [LEVEL_W-1:0] quantize_bin(
      input logic signed [SAMPLE_W-1:0] coef,
      input logic signed [BEXP_W-1:0]   bexp
   );
      longint      wide;
      logic [63:0] mag, mant, prod, scaled, q;
      logic [15:0] lvl;
      int          e, eoff, oct, rsh, ls;
      wide = coef;
      mag  = coef[SAMPLE_W-1] ? 64'(-wide) : 64'(wide);
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;  // most negative sample

      // inverse step: Q28 mantissa and binary shift
      e    = int'(step_gain) + STEP_OFFSET - 2 * int'(bexp);
      eoff = e + 256;
      oct  = (eoff >>> 3) - 32;
      mant = eighth_octave_q30(3'(eoff & 7)) >> 2;
      rsh  = TOTAL_FRAC - int'(block_exp) - oct;
      prod = mag * mant;

      if (rsh >= 64) begin
         scaled = 64'd0;
      end else if (rsh > 0) begin
         scaled = prod >> rsh;
         if (scaled > Q8_LIMIT) scaled = Q8_LIMIT;
      end else begin
         ls = -rsh;
         if (prod == 64'd0) scaled = 64'd0;
         else if (ls >= 32 || prod > (Q8_LIMIT >> ls)) scaled = Q8_LIMIT;
         else scaled = prod << ls;
      end

      // deadzone, rounding, saturation, sign
      if (scaled < DEADZONE_Q8) begin
         q = 64'd0;
      end else begin
         q = (scaled + 64'(round_bias)) >> 8;
         if (q > LEVEL_LIMIT) q = LEVEL_LIMIT;
      end
      lvl = q[15:0];
      if (coef[SAMPLE_W-1]) lvl = -lvl;
      return lvl;
   endfunction

   always @(posedge clock) begin
      level_entry_type entry, want;
      int              fails, seen;
      if (reset) begin
         step_gain  = GAIN_RESET;
         block_exp  = SEXP_RESET;
         round_bias = BIAS_RESET;
         pending_levels.delete();
         fail_count  <= 0;
         outstanding <= 0;
         checked     <= 0;
      end else begin
         fails = fail_count;
         seen  = checked;

         // track register writes; the spare index is ignored
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STEP_GAIN:      step_gain  = csr_write_data[GAIN_W-1:0];
               CSR_BLOCK_EXPONENT: block_exp  = csr_write_data[SEXP_W-1:0];
               CSR_ROUND_BIAS:     round_bias = csr_write_data[BIAS_W-1:0];
               default: ;
            endcase
         end

         // predict on every accepted input word
         if (req_valid && !req_stall) begin
            entry.coef  = req_spectrum_sample;
            entry.bexp  = req_bin_exponent;
            entry.level = quantize_bin(req_spectrum_sample, req_bin_exponent);
            pending_levels.push_back(entry);
         end

         // compare every delivered result word
         if (rsp_valid && !rsp_stall) begin
            if (pending_levels.size() == 0) begin
               $display("%0t: quant_level %0d delivered with nothing pending",
                        $time, rsp_quant_level);
               fails++;
            end else begin
               want = pending_levels.pop_front();
               seen++;
               if (rsp_quant_level !== want.level) begin
                  $display("%0t: quant_level expected %0d actual %0d (sample %0d bexp %0d)",
                           $time, want.level, rsp_quant_level, want.coef, want.bexp);
                  fails++;
               end
            end
         end

         fail_count  <= fails;
         checked     <= seen;
         outstanding <= pending_levels.size();
      end
   end

endmodule

// File: bench/tb.sv
// ============================================================================
// tb
// Top of the deadzone spectral quantizer bench. Drives directed corner words
// and register settings, then random phases under three pacing modes; the
// level monitor predicts and checks every result word.
// ============================================================================
`timescale 1ns / 1ps
module tb
   import dsq_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int WORDS_PER_PHASE = 130;
   localparam int PHASES_PER_MODE = 5;
   localparam int NUM_MODES       = 3;

   logic                       clock;
   logic                       reset               = 1'b1;
   logic                       req_valid           = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_spectrum_sample = '0;
   logic signed [BEXP_W-1:0]   req_bin_exponent    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall           = 1'b0;
   logic signed [LEVEL_W-1:0]  rsp_quant_level;
   logic                       csr_write_enable    = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index           = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data      = '0;

   int fail_count, outstanding, checked;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int settings_used = 0;

   // stimulus copy of the registers, used to aim the random exponents
   logic [GAIN_W-1:0]        gain_set = GAIN_RESET;
   logic signed [SEXP_W-1:0] sexp_set = SEXP_RESET;

   deadzone_spectral_quantizer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_spectrum_sample (req_spectrum_sample),
      .req_bin_exponent    (req_bin_exponent),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_quant_level     (rsp_quant_level),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   quant_level_monitor u_monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_spectrum_sample (req_spectrum_sample),
      .req_bin_exponent    (req_bin_exponent),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_quant_level     (rsp_quant_level),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .fail_count          (fail_count),
      .outstanding         (outstanding),
      .checked             (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   // write all registers, then the spare index, which must be ignored
   task automatic program_regs(input logic [GAIN_W-1:0] gain,
                               input logic signed [SEXP_W-1:0] sexp,
                               input logic [BIAS_W-1:0] bias);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_STEP_GAIN;
      csr_write_data   <= gain;
      @(posedge clock);
      csr_index        <= CSR_BLOCK_EXPONENT;
      csr_write_data   <= {1'($urandom), sexp};
      @(posedge clock);
      csr_index        <= CSR_ROUND_BIAS;
      csr_write_data   <= bias;
      @(posedge clock);
      csr_index        <= CSR_SPARE;
      csr_write_data   <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      gain_set = gain;
      sexp_set = sexp;
      settings_used++;
   endtask

   // offer one word, with random idle gaps ahead of it
   task automatic send_bin(input logic signed [SAMPLE_W-1:0] coef,
                           input logic signed [BEXP_W-1:0] bexp);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_spectrum_sample <= coef;
      req_bin_exponent    <= bexp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait until every predicted level has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // extremes often, anything else otherwise
   function automatic int pick_field(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0: return lo;
         1: return hi;
         default: return lo + int'($urandom_range(0, hi - lo));
      endcase
   endfunction

   // random word; most exponents are aimed so the shift lands where levels vary
   task automatic random_bin();
      logic signed [SAMPLE_W-1:0] coef;
      int                         kind, t, e, b;
      kind = $urandom_range(0, 9);
      coef = $urandom;
      coef = coef >>> $urandom_range(0, 31);
      if (kind == 0) begin
         case ($urandom_range(0, 4))
            0: coef = 32'sh8000_0000;
            1: coef = 32'sh7FFF_FFFF;
            2: coef = 32'sh0000_0000;
            3: coef = 32'sh0000_0001;
            default: coef = -32'sh0000_0001;
         endcase
      end
      if (kind <= 1) begin
         b = int'($urandom_range(0, 191)) - 64;
      end else begin
         t = $urandom_range(20, 70);
         e = 8 * (51 - int'(sexp_set) - t) + int'($urandom_range(0, 7));
         b = (int'(gain_set) + 59 - e) >>> 1;
         if (b < -64) b = -64;
         if (b > 127) b = 127;
      end
      send_bin(coef, BEXP_W'(b));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 14;
      rx_idle_pct <= 54;

      // reset settings: zero, full scale, most negative, coarse step, deadzone
      send_bin(32'sh0000_0000, 8'sd0);
      send_bin(32'sh7FFF_FFFF, -8'sd64);
      send_bin(32'sh8000_0000, -8'sd64);
      send_bin(32'sh8000_0000, 8'sd0);
      send_bin(32'sh7FFF_FFFF, 8'sd0);
      send_bin(32'sh0000_0001, 8'sd127);
      send_bin(-32'sh0010_0000, 8'sd0);
      send_bin(-32'sh0000_0001, -8'sd1);
      send_bin(32'sh1234_5678, 8'sd10);
      drain();

      // finest step: deep left shifts
      program_regs(8'd255, 7'sd63, 8'd255);
      send_bin(32'sh7FFF_FFFF, -8'sd64);
      send_bin(32'sh0000_0000, -8'sd64);
      send_bin(-32'sh0000_0005, 8'sd127);
      send_bin(32'sh8000_0000, 8'sd127);
      drain();

      // shift of minus one: the unsaturated and saturated left shift paths
      program_regs(8'd0, 7'sd63, 8'd0);
      send_bin(32'sh0000_0003, 8'sd72);
      send_bin(32'sh0000_0007, 8'sd72);
      send_bin(-32'sh0000_0003, 8'sd72);
      drain();

      // coarsest step: everything falls to zero
      program_regs(8'd0, -7'sd64, 8'd0);
      send_bin(32'sh7FFF_FFFF, 8'sd127);
      send_bin(32'sh8000_0000, -8'sd64);
      send_bin(-32'sh7FFF_FFFF, 8'sd40);
      drain();

      // random phases under three pacing modes
      for (int mode = 0; mode < NUM_MODES; mode++) begin
         case (mode)
            0: begin tx_idle_pct = 14; rx_idle_pct <= 54; end
            1: begin tx_idle_pct = 54; rx_idle_pct <= 14; end
            default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
         endcase
         for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
            program_regs(GAIN_W'(pick_field(0, 255)),
                         SEXP_W'(pick_field(-64, 63)),
                         BIAS_W'(pick_field(0, 255)));
            for (int n = 0; n < WORDS_PER_PHASE; n++) random_bin();
            drain();
         end
      end

      repeat (8) @(posedge clock);
      $display("Checked %0d quantized words across %0d register settings,",
               checked, settings_used);
      $display("with sender and receiver pacing varied between phases.");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/dsq_pkg.sv
design/dsq_skid.sv
design/dsq_prep.sv
design/dsq_scale.sv
design/dsq_level.sv
design/deadzone_spectral_quantizer.sv
design/dsq_checker.sv
bench/quant_level_monitor.sv
bench/tb.sv
